[hw/rtl/wpsq_pkg.sv]
// ----------------------------------------------------------------------------
// wpsq_pkg
// shared widths, codes and the stored entry layout of the sorted queue
// ----------------------------------------------------------------------------
package wpsq_pkg;

  localparam int unsigned PAYLOAD_W  = 32;
  localparam int unsigned GRADE_W    = 14;
  localparam int unsigned COURSES_W  = 8;
  localparam int unsigned KEY_W      = 25;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned PROD_W     = GRADE_W + COURSES_W;
  localparam int unsigned CFG_DATA_W = 14;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_POP  = 2'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  localparam logic CFG_GRADE_SCALE = 1'b0;
  localparam logic CFG_COURSE_SPAN = 1'b1;

  localparam logic [GRADE_W-1:0]   GRADE_SCALE_RST = 14'd1000;
  localparam logic [COURSES_W-1:0] COURSE_SPAN_RST = 8'd30;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [COURSES_W-1:0] courses;
    logic [GRADE_W-1:0]   grade;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

[hw/rtl/weighted_priority_sorted_queue_core.sv]
// ----------------------------------------------------------------------------
// weighted_priority_sorted_queue_core
// bounded priority queue sorted by a weighted key, held in one memory
// ----------------------------------------------------------------------------
// A command word (push, pop, peek) is taken only while the sequencer is idle,
// and each command returns one result word describing the front entry. The
// entries sit in one single-port-read memory, front at address 0, sorted by
// descending key, newest first among equal keys. A push first computes its
// key (S_KEY1, S_KEY2), then walks from the tail toward the front, each entry
// in two steps (read, then compare and move down one slot), until it meets a
// strictly greater key or passes the front, and writes the new entry behind
// that key or at the front. A pop moves every remaining entry up one slot,
// read then write for each. A peek, a dropped push or an empty pop only reads
// the front entry. The memory read of the front entry ends every command, and
// the sequencer then waits until the output register is free. A finished
// result waits in the output register while the next command is accepted.
module weighted_priority_sorted_queue_core
  import wpsq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // command channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,  // payload, grade, courses
  input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd
  // result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [87:0]           m_axis_tdata,  // front_payload, front_grade,
                                               // front_courses, front_key,
                                               // entry_count, is_empty
  output logic [STATUS_W-1:0]   m_axis_tuser,  // status
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned OW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = $bits(entry_t);

  typedef enum logic [3:0] {
    S_IDLE, S_KEY1, S_KEY2, S_PUSH_RD, S_PUSH_CMP, S_PUSH_HEAD,
    S_POP_RD, S_POP_WR, S_FRONT_RD, S_FRONT
  } state_e;

  state_e                state_q;
  logic [OW-1:0]         occ_q;
  logic [AW-1:0]         idx_q;
  logic [STATUS_W-1:0]   status_q;
  logic [GRADE_W-1:0]    grade_scale_q;
  logic [COURSES_W-1:0]  course_span_q;

  // latched command word
  logic [PAYLOAD_W-1:0]  payload_q;
  logic [GRADE_W-1:0]    grade_q;
  logic [COURSES_W-1:0]  courses_q;

  // result register
  logic                  out_valid_q;
  logic [87:0]           out_data_q;
  logic [STATUS_W-1:0]   out_user_q;

  logic [KEY_W-1:0]      key;
  entry_t                new_entry, rd_entry, wr_entry;
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [EW-1:0]         ram_rdata;
  logic                  in_fire, out_free;
  logic [87:0]           res_data;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  wpsq_key u_key (
    .clk_i         (clk_i),
    .grade_i       (grade_q),
    .courses_i     (courses_q),
    .grade_scale_i (grade_scale_q),
    .course_span_i (course_span_q),
    .key_o         (key)
  );

  assign new_entry = '{key: key, courses: courses_q, grade: grade_q, payload: payload_q};
  assign rd_entry  = entry_t'(ram_rdata);

  wpsq_ram #(
    .Width (EW),
    .Depth (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_entry),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // memory port control: every access of a step lands before the next read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    wr_entry  = rd_entry;
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    unique case (state_q)
      S_PUSH_RD, S_POP_RD: begin
        ram_re = 1'b1;
      end
      S_PUSH_CMP: begin
        // entry ahead has a strictly greater key: new entry lands behind it
        ram_we    = 1'b1;
        ram_waddr = idx_q + AW'(1);
        wr_entry  = (rd_entry.key > key) ? new_entry : rd_entry;
      end
      S_PUSH_HEAD: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        wr_entry  = new_entry;
      end
      S_POP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q - AW'(1);
      end
      S_FRONT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      default: ;
    endcase
  end

  // result fields; the front entry fields are zero when the queue is empty
  always_comb begin
    res_data = '0;
    if (occ_q != '0) begin
      res_data[31:0]  = rd_entry.payload;
      res_data[45:32] = rd_entry.grade;
      res_data[53:46] = rd_entry.courses;
      res_data[78:54] = rd_entry.key;
    end
    res_data[83:79] = COUNT_W'(occ_q);
    res_data[84]    = (occ_q == '0);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      payload_q <= s_axis_tdata[31:0];
      grade_q   <= s_axis_tdata[45:32];
      courses_q <= s_axis_tdata[53:46];
    end
    if (state_q == S_FRONT && out_free) begin
      out_data_q <= res_data;
      out_user_q <= status_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      occ_q         <= '0;
      idx_q         <= '0;
      status_q      <= STATUS_OK;
      out_valid_q   <= 1'b0;
      grade_scale_q <= GRADE_SCALE_RST;
      course_span_q <= COURSE_SPAN_RST;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRADE_SCALE: grade_scale_q <= cfg_data_i[GRADE_W-1:0];
          CFG_COURSE_SPAN: course_span_q <= cfg_data_i[COURSES_W-1:0];
          default: ;
        endcase
      end
      // result register: load a new word or drop the taken one
      if (state_q == S_FRONT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (s_axis_tuser == CMD_PUSH) begin
              if (occ_q >= OW'(CAPACITY)) begin
                status_q <= STATUS_FULL;
                state_q  <= S_FRONT_RD;
              end else begin
                status_q <= STATUS_OK;
                state_q  <= S_KEY1;
              end
            end else if (s_axis_tuser == CMD_POP) begin
              if (occ_q == '0) begin
                status_q <= STATUS_EMPTY;
                state_q  <= S_FRONT_RD;
              end else if (occ_q == OW'(1)) begin
                status_q <= STATUS_OK;
                occ_q    <= '0;
                state_q  <= S_FRONT_RD;
              end else begin
                status_q <= STATUS_OK;
                idx_q    <= AW'(1);
                state_q  <= S_POP_RD;
              end
            end else begin
              // peek and the unused code only report
              status_q <= STATUS_OK;
              state_q  <= S_FRONT_RD;
            end
          end
        end
        S_KEY1: state_q <= S_KEY2;
        S_KEY2: begin
          if (occ_q == '0) begin
            state_q <= S_PUSH_HEAD;
          end else begin
            idx_q   <= AW'(occ_q - OW'(1));
            state_q <= S_PUSH_RD;
          end
        end
        S_PUSH_RD: state_q <= S_PUSH_CMP;
        S_PUSH_CMP: begin
          if (rd_entry.key > key) begin
            occ_q   <= occ_q + OW'(1);
            state_q <= S_FRONT_RD;
          end else if (idx_q == '0) begin
            state_q <= S_PUSH_HEAD;
          end else begin
            idx_q   <= idx_q - AW'(1);
            state_q <= S_PUSH_RD;
          end
        end
        S_PUSH_HEAD: begin
          occ_q   <= occ_q + OW'(1);
          state_q <= S_FRONT_RD;
        end
        S_POP_RD: state_q <= S_POP_WR;
        S_POP_WR: begin
          if (OW'(idx_q) == occ_q - OW'(1)) begin
            occ_q   <= occ_q - OW'(1);
            state_q <= S_FRONT_RD;
          end else begin
            idx_q   <= idx_q + AW'(1);
            state_q <= S_POP_RD;
          end
        end
        S_FRONT_RD: state_q <= S_FRONT;
        S_FRONT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // checks

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OW'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q)) |-> (occ_q == $past(occ_q) + OW'(1) ||
                                 occ_q == $past(occ_q) - OW'(1)))
    else $error("occupancy moved by more than one");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[84]) |-> (m_axis_tdata[83:0] == '0))
    else $error("empty result carries front data");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRONT && status_q == STATUS_FULL) |-> (occ_q == OW'(CAPACITY)))
    else $error("push dropped while not full");

endmodule

[hw/rtl/wpsq_ram.sv]
// ----------------------------------------------------------------------------
// wpsq_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module wpsq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/wpsq_key.sv]
// ----------------------------------------------------------------------------
// wpsq_key
// two-stage weighted key unit: products, then scaled sum with saturation
// ----------------------------------------------------------------------------
module wpsq_key
  import wpsq_pkg::*;
(
  input  logic                 clk_i,
  input  logic [GRADE_W-1:0]   grade_i,
  input  logic [COURSES_W-1:0] courses_i,
  input  logic [GRADE_W-1:0]   grade_scale_i,
  input  logic [COURSES_W-1:0] course_span_i,
  output logic [KEY_W-1:0]     key_o
);

  logic [PROD_W-1:0] prod_g_q, prod_c_q;
  logic [PROD_W+3:0] sum;
  logic [KEY_W-1:0]  key_q;

  always_ff @(posedge clk_i) begin
    prod_g_q <= PROD_W'(grade_i) * PROD_W'(course_span_i);
    prod_c_q <= PROD_W'(courses_i) * PROD_W'(grade_scale_i);
    key_q    <= (sum[PROD_W+3:KEY_W] != '0) ? '1 : sum[KEY_W-1:0];
  end

  assign sum   = (PROD_W+4)'(prod_g_q) * (PROD_W+4)'(3)
               + (PROD_W+4)'(prod_c_q) * (PROD_W+4)'(7);
  assign key_o = key_q;

endmodule

[bench/wpsq_scoreboard.sv]
// ----------------------------------------------------------------------------
// wpsq_scoreboard
// watches the command, result and configuration channels of the sorted queue,
// keeps a mirror of the queue and compares every result word with it
// ----------------------------------------------------------------------------
module wpsq_scoreboard
  import wpsq_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,
  input  logic [CMD_W-1:0]      s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [87:0]           m_axis_tdata,
  input  logic [STATUS_W-1:0]   m_axis_tuser,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_o,
  input  logic                  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    pending_o,
  output int                    errors_o
);

  typedef struct {
    logic [STATUS_W-1:0]  status;
    logic [PAYLOAD_W-1:0] payload;
    logic [GRADE_W-1:0]   grade;
    logic [COURSES_W-1:0] courses;
    logic [KEY_W-1:0]     key;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } front_report_t;

  entry_t               mirror [CAPACITY];
  int unsigned          fill;
  logic [GRADE_W-1:0]   grade_scale;
  logic [COURSES_W-1:0] course_span;
  front_report_t        expected_reports [$];
  int                   errors;

  assign pending_o = expected_reports.size();
  assign errors_o  = errors;

  // scaled weighted sum, saturated to the key width
  function automatic logic [KEY_W-1:0] weigh(logic [GRADE_W-1:0] g, logic [COURSES_W-1:0] c);
    longint unsigned k;
    k = 64'd3 * g * course_span + 64'd7 * c * grade_scale;
    if (k > {KEY_W{1'b1}}) k = {KEY_W{1'b1}};
    return k[KEY_W-1:0];
  endfunction

  function automatic front_report_t apply_command(logic [CMD_W-1:0] cmd, logic [55:0] d);
    front_report_t r;
    entry_t        e;
    int unsigned   pos;
    r.status = STATUS_OK;
    if (cmd == CMD_PUSH) begin
      if (fill >= CAPACITY) begin
        r.status = STATUS_FULL;
      end else begin
        e.payload = d[31:0];
        e.grade   = d[45:32];
        e.courses = d[53:46];
        e.key     = weigh(e.grade, e.courses);
        pos = 0;
        while (pos < fill && mirror[pos].key > e.key) pos++;
        for (int unsigned i = fill; i > pos; i--) mirror[i] = mirror[i-1];
        mirror[pos] = e;
        fill++;
      end
    end else if (cmd == CMD_POP) begin
      if (fill == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        for (int unsigned i = 1; i < fill; i++) mirror[i-1] = mirror[i];
        fill--;
      end
    end
    // every command reports the front entry; peek and the unused code do nothing else
    if (fill > 0) begin
      r.payload = mirror[0].payload;
      r.grade   = mirror[0].grade;
      r.courses = mirror[0].courses;
      r.key     = mirror[0].key;
    end else begin
      r.payload = '0;
      r.grade   = '0;
      r.courses = '0;
      r.key     = '0;
    end
    r.count = fill[COUNT_W-1:0];
    r.empty = (fill == 0);
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    errors      = 0;
    fill        = 0;
    grade_scale = GRADE_SCALE_RST;
    course_span = COURSE_SPAN_RST;
  end

  always @(posedge clk_i) begin
    front_report_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_GRADE_SCALE) grade_scale = cfg_data_i;
        else course_span = cfg_data_i[COURSES_W-1:0];
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_reports.push_back(apply_command(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_reports.size() == 0) begin
          $error("result word with no command waiting for it");
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", want.status, m_axis_tuser);
          check_field("front_payload", want.payload, m_axis_tdata[31:0]);
          check_field("front_grade", want.grade, m_axis_tdata[45:32]);
          check_field("front_courses", want.courses, m_axis_tdata[53:46]);
          check_field("front_key", want.key, m_axis_tdata[78:54]);
          check_field("entry_count", want.count, m_axis_tdata[83:79]);
          check_field("is_empty", want.empty, m_axis_tdata[84]);
        end
      end
    end
  end

endmodule

[bench/weighted_priority_sorted_queue_core_test.sv]
// ----------------------------------------------------------------------------
// weighted_priority_sorted_queue_core_test
// drives push, pop, peek and unused-code words and configuration writes into the
// sorted queue with random idling on both sides; the scoreboard checks each result
// ----------------------------------------------------------------------------
module weighted_priority_sorted_queue_core_test;
  import wpsq_pkg::*;

  localparam int          DEPTH       = CAPACITY_DEF;
  localparam int          SETTLE      = 60;       // longest command plus margin
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [55:0]           s_axis_tdata;   // payload, grade, courses, zero pad
  logic [CMD_W-1:0]      s_axis_tuser;   // cmd
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [87:0]           m_axis_tdata;   // front_payload, front_grade, front_courses,
                                         // front_key, entry_count, is_empty, zero pad
  logic [STATUS_W-1:0]   m_axis_tuser;   // status
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic                  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int          pending;
  int          errors;
  int unsigned cycles;
  int unsigned words_sent;
  bit          calm;          // no idling in the last part of the run
  bit          backlog_done;  // the long receiver hold-off has happened

  weighted_priority_sorted_queue_core #(.CAPACITY(DEPTH)) u_dut (.*);

  wpsq_scoreboard #(.CAPACITY(DEPTH)) u_scoreboard (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // 12 unit clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // hard stop in case the block hangs
  initial cycles = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("weighted_priority_sorted_queue_core_test: FAIL");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off so the queue backs up
  initial begin
    m_axis_tready = 1'b0;
    backlog_done  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!backlog_done && words_sent >= 160) begin
        backlog_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // one command word, with an occasional gap in front of it
  task automatic send_word(logic [CMD_W-1:0] cmd, logic [31:0] payload,
                           logic [GRADE_W-1:0] grade, logic [COURSES_W-1:0] courses);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, courses, grade, payload};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
  endtask

  task automatic stop_words();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  // queue drained of results, then let any silent work finish
  task automatic wait_idle();
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic index, logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // random traffic; the push/pop balance drifts so the queue swings full and empty
  task automatic random_words(int n);
    int                   push_pct;
    int                   roll;
    logic [GRADE_W-1:0]   grade;
    logic [COURSES_W-1:0] courses;
    grade    = '0;
    courses  = '0;
    push_pct = 50;
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) push_pct = $urandom_range(20, 80);
      roll = $urandom_range(0, 99);
      // reuse the previous grade and count now and then for equal keys
      if ($urandom_range(0, 4) != 0) begin
        grade   = ($urandom_range(0, 9) == 0) ? GRADE_W'($urandom)
                                              : GRADE_W'($urandom_range(0, 10000));
        courses = COURSES_W'($urandom);
      end
      if (roll < push_pct)
        send_word(CMD_PUSH, $urandom, grade, courses);
      else if (roll < 92)
        send_word(CMD_POP, $urandom, GRADE_W'($urandom), COURSES_W'($urandom));
      else if (roll < 97)
        send_word(CMD_PEEK, $urandom, GRADE_W'($urandom), COURSES_W'($urandom));
      else
        send_word(CMD_UNUSED, $urandom, GRADE_W'($urandom), COURSES_W'($urandom));
    end
    stop_words();
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CMD_PEEK;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_GRADE_SCALE;
    cfg_data_i    = '0;
    calm          = 1'b0;
    words_sent    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty cases, field extremes, equal keys, overfill, three pops
    send_word(CMD_POP, 32'h0, 14'd0, 8'd0);
    send_word(CMD_PEEK, 32'hffff_ffff, 14'h3fff, 8'hff);
    send_word(CMD_UNUSED, 32'h0, 14'd0, 8'd0);
    send_word(CMD_PUSH, 32'h0, 14'd0, 8'd0);
    send_word(CMD_PUSH, 32'hffff_ffff, 14'd10000, 8'd255);
    send_word(CMD_PUSH, 32'h5555_aaaa, 14'h3fff, 8'hff);      // largest grade and courses
    send_word(CMD_PUSH, 32'h1234_5678, 14'd5000, 8'd10);
    send_word(CMD_PUSH, 32'h8765_4321, 14'd5000, 8'd10);      // equal key, newest first
    for (int i = 0; i < 12; i++)
      send_word(CMD_PUSH, $urandom, GRADE_W'($urandom_range(0, 10000)),
                COURSES_W'($urandom));
    send_word(CMD_PUSH, 32'hdead_beef, 14'd1, 8'd1);          // dropped when full
    send_word(CMD_PEEK, 32'h0, 14'd0, 8'd0);
    for (int i = 0; i < 3; i++) send_word(CMD_POP, 32'h0, 14'd0, 8'd0);
    stop_words();
    wait_idle();

    // configuration phases, extremes included
    write_reg(CFG_GRADE_SCALE, 14'd1);
    write_reg(CFG_COURSE_SPAN, 14'd1);
    random_words(250);
    wait_idle();
    write_reg(CFG_GRADE_SCALE, 14'h3fff);
    write_reg(CFG_COURSE_SPAN, 14'd255);
    random_words(250);
    wait_idle();
    write_reg(CFG_GRADE_SCALE, 14'd0);
    write_reg(CFG_COURSE_SPAN, 14'h3f00);                     // upper bits ignored
    random_words(200);
    wait_idle();
    write_reg(CFG_GRADE_SCALE, 14'd10000);
    write_reg(CFG_COURSE_SPAN, 14'd0);
    random_words(200);
    wait_idle();
    write_reg(CFG_GRADE_SCALE, CFG_DATA_W'($urandom_range(1, 10000)));
    write_reg(CFG_COURSE_SPAN, CFG_DATA_W'($urandom_range(1, 255)));
    random_words(200);
    wait_idle();

    // last part runs flat out
    calm = 1'b1;
    write_reg(CFG_GRADE_SCALE, 14'd1000);
    write_reg(CFG_COURSE_SPAN, 14'd30);
    random_words(200);
    wait_idle();

    if (errors == 0)
      $display("weighted_priority_sorted_queue_core_test: PASS");
    else
      $display("weighted_priority_sorted_queue_core_test: FAIL");
    $finish;
  end

endmodule
